@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define ACFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deframer assertion failed");
// Check that expr never holds at a clock edge outside reset.
`define ACFD_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("deframer forbidden condition seen");
`else
`define ACFD_ASSERT(lbl, clk, rstn, prop)
`define ACFD_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/core/acfd_pkg.sv @@
// Package: types, codes and constants of the Adler-32 checked frame deframer.
`default_nettype none

package acfd_pkg;

    localparam int          TAG_BYTES_DEFAULT = 4;
    localparam logic [30:0] MAX_LENGTH_RESET  = 31'd67108864;
    localparam logic [15:0] ADLER_MOD         = 16'd65521;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [1:0] REG_TAG_VALUE  = 2'd1;
    localparam logic [1:0] REG_TAG_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_TAG      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    typedef struct packed {
        logic add;
        logic restart;
    } adler_ctrl_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/adler32_checked_frame_deframer.sv @@
// Top level: config registers, parser, Adler-32 unit and result register.
//
//  channel   dir  handshake            payload
//  s_ (in)   in   s_tvalid/s_tready    s_tdata = data_byte
//  m_ (out)  out  m_tvalid/m_tready    m_tdata = out_byte, m_tlast = frame_end,
//                                      m_tuser = status
//  cfg       in   cfg_wr_en            cfg_index, cfg_wdata
//
// One input beat per cycle while s_tready is high.
// The frame state and the running Adler-32 sums update on the accepting edge;
// a payload or status beat then sits in the single output register.
// s_tready is high whenever that register is empty or drains in this cycle,
// so a full stream runs at one beat per clock with m_tready held high.
// aresetn (synchronous, active low) clears config to defaults and the frame
// state to the header phase; after any error status the block drops beats
// until the next reset.
`default_nettype none
`include "assert_macros.svh"

module adler32_checked_frame_deframer #(
    parameter int TAG_BYTES = acfd_pkg::TAG_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic             m_tlast,    // frame_end
    output logic [1:0]       m_tuser,    // [1:0] status
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import acfd_pkg::*;

    logic [30:0] max_length_reg;
    logic [31:0] tag_value_reg;
    logic [2:0]  tag_length_reg;

    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg,   out_res_next;

    logic        in_accept;
    logic        res_valid;
    result_t     res;
    adler_ctrl_t adler_ctrl;
    logic [31:0] adler_sum;

    // Configuration registers: take each write at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
            tag_value_reg  <= 32'd0;
            tag_length_reg <= 3'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_LENGTH: max_length_reg <= cfg_wdata[30:0];
                REG_TAG_VALUE:  tag_value_reg  <= cfg_wdata;
                REG_TAG_LENGTH: tag_length_reg <= cfg_wdata[2:0];
                default:        ;
            endcase
        end
    end

    // Accept a beat whenever the result register is free or draining.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    acfd_parser #(
        .TAG_BYTES (TAG_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .max_length (max_length_reg),
        .tag_value  (tag_value_reg),
        .tag_length (tag_length_reg),
        .adler_sum  (adler_sum),
        .adler_ctrl (adler_ctrl),
        .res_valid  (res_valid),
        .res        (res)
    );

    acfd_adler u_adler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (adler_ctrl),
        .data_byte (s_tdata),
        .sum       (adler_sum)
    );

    // Result register: load a new beat, drop a taken one, hold otherwise.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_byte;
    assign m_tlast  = out_res_reg.frame_end;
    assign m_tuser  = out_res_reg.status;

    // Payload beats never carry a status code.
    `ACFD_NEVER(a_payload_no_status, aclk, aresetn, m_tvalid && !m_tlast && (m_tuser != ST_OK))
    // Status beats carry a zero data byte.
    `ACFD_NEVER(a_status_zero_byte, aclk, aresetn, m_tvalid && m_tlast && (m_tdata != 8'h00))
    // After an error status is taken, nothing more comes out.
    `ACFD_ASSERT(a_halt_after_error, aclk, aresetn, (m_tvalid && m_tready && m_tlast && (m_tuser != ST_OK)) |=> !m_tvalid)
    // A result appears only after an accepted input beat.
    `ACFD_ASSERT(a_result_needs_input, aclk, aresetn, ($rose(m_tvalid)) |-> $past(in_accept))

endmodule

`default_nettype wire

@@ rtl/core/acfd_adler.sv @@
// Running Adler-32 sums, one byte per cycle while ctrl.add is set.
`default_nettype none

module acfd_adler (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire acfd_pkg::adler_ctrl_t ctrl,
    input  wire logic [7:0]           data_byte,
    output logic      [31:0]          sum
);
    import acfd_pkg::*;

    logic [15:0] low_reg,  low_next;
    logic [15:0] high_reg, high_next;
    logic [16:0] low_add;
    logic [16:0] high_add;
    logic [15:0] low_upd;
    logic [15:0] high_upd;

    always_comb begin
        low_add  = {1'b0, low_reg} + {9'd0, data_byte};
        low_upd  = (low_add >= {1'b0, ADLER_MOD}) ? 16'(low_add - {1'b0, ADLER_MOD})
                                                  : low_add[15:0];
        high_add = {1'b0, high_reg} + {1'b0, low_upd};
        high_upd = (high_add >= {1'b0, ADLER_MOD}) ? 16'(high_add - {1'b0, ADLER_MOD})
                                                   : high_add[15:0];
    end

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (ctrl.restart) begin
            low_next  = 16'd1;
            high_next = 16'd0;
        end else if (ctrl.add) begin
            low_next  = low_upd;
            high_next = high_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= 16'd1;
            high_reg <= 16'd0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign sum = {high_reg, low_reg};

endmodule

`default_nettype wire

@@ rtl/core/acfd_parser.sv @@
// Frame parser: header phase, body phase (tag, payload and checksum) and halt phase.
`default_nettype none

module acfd_parser #(
    parameter int TAG_BYTES = acfd_pkg::TAG_BYTES_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_accept,
    input  wire logic [7:0]             in_byte,
    input  wire logic [30:0]            max_length,
    input  wire logic [31:0]            tag_value,
    input  wire logic [2:0]             tag_length,
    input  wire logic [31:0]            adler_sum,
    output acfd_pkg::adler_ctrl_t       adler_ctrl,
    output logic                        res_valid,
    output acfd_pkg::result_t           res
);
    import acfd_pkg::*;

    localparam logic [3:0] TAG_CAP = 4'(TAG_BYTES);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [23:0] hdr_shift_reg, hdr_shift_next;
    logic [30:0] remain_reg,    remain_next;
    logic [3:0]  tag_cnt_reg,   tag_cnt_next;
    logic        tag_bad_reg,   tag_bad_next;
    logic [23:0] chk_reg,       chk_next;

    logic [3:0]  tag_n;
    logic [31:0] hdr_word;
    logic        hdr_done;
    logic        len_bad;
    logic        in_chk;
    logic        is_last;
    logic        in_tag;
    logic [2:0]  tag_idx;
    logic [7:0]  tag_want;
    status_t     end_status;

    always_comb begin
        tag_n    = ({1'b0, tag_length} > TAG_CAP) ? TAG_CAP : {1'b0, tag_length};
        hdr_word = {hdr_shift_reg, in_byte};
        hdr_done = (hdr_cnt_reg == 2'd3);
        len_bad  = hdr_word[31]
                 || (hdr_word[30:0] > max_length)
                 || (hdr_word[30:0] < (31'(tag_n) + 31'd4));
        in_chk   = (remain_reg <= 31'd4);
        is_last  = (remain_reg == 31'd1);
        in_tag   = (tag_cnt_reg < tag_n);
        tag_idx  = 3'(tag_n - 4'd1 - tag_cnt_reg);
        tag_want = tag_idx[2] ? 8'h00 : tag_value[{tag_idx[1:0], 3'b000} +: 8];
        if (adler_sum != {chk_reg, in_byte}) begin
            end_status = ST_CHECKSUM;
        end else if (tag_bad_reg) begin
            end_status = ST_TAG;
        end else begin
            end_status = ST_OK;
        end
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HEADER: begin
                if (in_accept && hdr_done) begin
                    phase_next = len_bad ? PH_HALT : PH_BODY;
                end
            end
            PH_BODY: begin
                if (in_accept && is_last) begin
                    phase_next = (end_status != ST_OK) ? PH_HALT : PH_HEADER;
                end
            end
            PH_HALT:   phase_next = PH_HALT;
            default:   phase_next = PH_HEADER;
        endcase
    end

    // Results and datapath updates
    always_comb begin
        hdr_cnt_next       = hdr_cnt_reg;
        hdr_shift_next     = hdr_shift_reg;
        remain_next        = remain_reg;
        tag_cnt_next       = tag_cnt_reg;
        tag_bad_next       = tag_bad_reg;
        chk_next           = chk_reg;
        adler_ctrl.add     = 1'b0;
        adler_ctrl.restart = 1'b0;
        res_valid          = 1'b0;
        res.out_byte       = 8'h00;
        res.frame_end      = 1'b0;
        res.status         = ST_OK;
        case (phase_reg)
            PH_HEADER: begin
                if (in_accept) begin
                    hdr_cnt_next   = hdr_cnt_reg + 2'd1;
                    hdr_shift_next = hdr_word[23:0];
                    if (hdr_done) begin
                        remain_next  = hdr_word[30:0];
                        tag_cnt_next = 4'd0;
                        tag_bad_next = 1'b0;
                        if (len_bad) begin
                            res_valid     = 1'b1;
                            res.frame_end = 1'b1;
                            res.status    = ST_LENGTH;
                        end
                    end
                end
            end
            PH_BODY: begin
                if (in_accept) begin
                    remain_next = remain_reg - 31'd1;
                    if (in_chk) begin
                        chk_next = {chk_reg[15:0], in_byte};
                        if (is_last) begin
                            adler_ctrl.restart = 1'b1;
                            tag_bad_next       = 1'b0;
                            res_valid          = 1'b1;
                            res.frame_end      = 1'b1;
                            res.status         = end_status;
                        end
                    end else begin
                        adler_ctrl.add = 1'b1;
                        if (tag_cnt_reg < TAG_CAP) begin
                            tag_cnt_next = tag_cnt_reg + 4'd1;
                        end
                        if (in_tag) begin
                            if (tag_want != in_byte) begin
                                tag_bad_next = 1'b1;
                            end
                        end else begin
                            res_valid    = 1'b1;
                            res.out_byte = in_byte;
                        end
                    end
                end
            end
            PH_HALT: begin
                res_valid = 1'b0;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= 2'd0;
            remain_reg  <= 31'd0;
            tag_cnt_reg <= 4'd0;
            tag_bad_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            remain_reg  <= remain_next;
            tag_cnt_reg <= tag_cnt_next;
            tag_bad_reg <= tag_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_shift_reg <= hdr_shift_next;
        chk_reg       <= chk_next;
    end

endmodule

`default_nettype wire

@@ dv/tb_adler32_checked_frame_deframer.sv @@
// Self-checking testbench for the Adler-32 checked frame deframer.
module tb_adler32_checked_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import acfd_pkg::*;

    localparam int          ADLER_PRIME = 65521;
    localparam int          QUIET_LIMIT = 5000;   // cycles with no beat, config or reset
    localparam int          HOLD_CYCLES = 600;    // long receiver hold-off
    localparam int          SETTLE      = 4;      // pause after the last result of a phase
    localparam int          MAX_PRINTS  = 40;

    // One row of the directed table: a stream byte and the result typed in for it.
    typedef struct packed {
        logic [7:0] din;
        logic       has;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_RES = '0;
    localparam result_t END_OK = '{8'h00, 1'b1, ST_OK};

    // Three frames after reset (no tag, default max length):
    // empty payload, payload FF 00, payload 7F. Checksums worked out by hand.
    localparam dir_row_t DIR_ROWS [0:26] = '{
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h04, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b1, END_OK},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h06, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{8'hFF, 1'b0, ST_OK}},
        '{8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{8'h02, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b1, END_OK},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h05, 1'b0, NO_RES},
        '{8'h7F, 1'b1, '{8'h7F, 1'b0, ST_OK}},
        '{8'h00, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h80, 1'b1, END_OK}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Pinned expectation travels with the beat: when pin_on is set, the typed
    // result replaces the predicted one.
    logic        pin_on   = 1'b0;
    logic        pin_has  = 1'b0;
    result_t     pin_want = '0;

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    logic        hold_on    = 1'b0;
    int          bytes_sent = 0;
    int          mismatches = 0;
    int          quiet      = 0;
    event        hold_ev;

    result_t     expected_beats[$];

    // Predictor state: configuration mirror and frame parser.
    logic [30:0] max_len;
    logic [31:0] tag_word;
    logic [2:0]  tag_len;
    phase_t      fr_phase;
    logic [31:0] len_word;
    logic [31:0] body_count;
    logic [15:0] sum_lo;
    logic [15:0] sum_hi;
    logic        tag_wrong;
    logic [31:0] sum_seen;

    always #5 aclk = ~aclk;

    adler32_checked_frame_deframer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void adler_step(inout logic [15:0] lo, inout logic [15:0] hi,
                                       input logic [7:0] b);
        logic [16:0] t;
        t = {1'b0, lo} + b;
        if (t >= ADLER_PRIME) t = t - 17'(ADLER_PRIME);
        lo = t[15:0];
        t = {1'b0, hi} + lo;
        if (t >= ADLER_PRIME) t = t - 17'(ADLER_PRIME);
        hi = t[15:0];
    endfunction

    // Tag bytes in use: the register value, capped at the tag capacity.
    function automatic int tag_span();
        return (tag_len > TAG_BYTES_DEFAULT) ? TAG_BYTES_DEFAULT : int'(tag_len);
    endfunction

    function automatic void clear_frame();
        len_word   = '0;
        body_count = '0;
        sum_lo     = 16'd1;
        sum_hi     = '0;
        tag_wrong  = 1'b0;
        sum_seen   = '0;
    endfunction

    function automatic void reset_predictor();
        max_len  = MAX_LENGTH_RESET;
        tag_word = '0;
        tag_len  = '0;
        fr_phase = PH_HEADER;
        clear_frame();
    endfunction

    // Advance the parser by one stream byte; return 1 when it yields a result beat.
    function automatic logic deframe_byte(input logic [7:0] b, output result_t r);
        logic [31:0] n;
        logic [31:0] k;
        logic [31:0] calc;
        status_t     st;
        r = '0;
        n = tag_span();
        case (fr_phase)
            PH_HEADER: begin
                len_word   = {len_word[23:0], b};
                body_count = body_count + 1;
                if (body_count < 4) return 1'b0;
                body_count = '0;
                // length check: negative, too long, or too short for tag and checksum
                if (len_word[31] || len_word[30:0] > max_len || len_word < n + 4) begin
                    fr_phase    = PH_HALT;
                    r.frame_end = 1'b1;
                    r.status    = ST_LENGTH;
                    return 1'b1;
                end
                fr_phase = PH_BODY;
                return 1'b0;
            end
            PH_BODY: begin
                k          = body_count;
                body_count = body_count + 1;
                if (k >= len_word - 4) begin
                    sum_seen = {sum_seen[23:0], b};
                    if (k + 1 < len_word) return 1'b0;
                    calc = {sum_hi, sum_lo};
                    // checksum error outranks a tag mismatch
                    if (calc != sum_seen) st = ST_CHECKSUM;
                    else if (tag_wrong)   st = ST_TAG;
                    else                  st = ST_OK;
                    clear_frame();
                    fr_phase    = (st != ST_OK) ? PH_HALT : PH_HEADER;
                    r.frame_end = 1'b1;
                    r.status    = st;
                    return 1'b1;
                end
                adler_step(sum_lo, sum_hi, b);
                if (k < n) begin
                    if (8'(tag_word >> (8 * (n - 1 - k))) != b) tag_wrong = 1'b1;
                    return 1'b0;
                end
                r.out_byte = b;
                return 1'b1;
            end
            default: return 1'b0;   // halted: drop everything
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking: compare each result beat with the oldest expectation, then
    // predict from the accepted input beat, then mirror config writes.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : scoreboard
        result_t want;
        result_t got;
        logic    has;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata, 8'h00);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch("out_byte", m_tdata, want.out_byte);
                    if (m_tlast !== want.frame_end)
                        report_mismatch("frame_end", 8'(m_tlast), 8'(want.frame_end));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 8'(m_tuser), 8'(want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                has = deframe_byte(s_tdata, got);
                if (pin_on) begin
                    has = pin_has;
                    got = pin_want;
                end
                if (has) expected_beats.push_back(got);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_LENGTH: max_len  = cfg_wdata[30:0];
                    REG_TAG_VALUE:  tag_word = cfg_wdata;
                    REG_TAG_LENGTH: tag_len  = cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_adler32_checked_frame_deframer: errors");
            $finish;
        end
    end

    // Receiver: random stalls, forced low during a hold-off.
    always @(negedge aclk) begin
        m_tready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
    end

    // Hold-off: count the stretch here, at rising edges, so the receiver sees
    // a stable flag at the falling edge.
    initial begin
        forever begin
            @(hold_ev);
            @(posedge aclk);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_on = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks; all start and end just after a falling edge.
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b, input logic pin, input logic has,
                            input result_t want);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        pin_on   <= pin;
        pin_has  <= has;
        pin_want <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [31:0] maxv, input logic [31:0] tv,
                              input logic [2:0] tn);
        cfg_write(REG_MAX_LENGTH, maxv);
        cfg_write(REG_TAG_VALUE, tv);
        // upper bits are don't-care; toggle them anyway
        cfg_write(REG_TAG_LENGTH, {29'($urandom), tn});
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Send one frame. fill < 0 means random payload bytes. spoil bit 0 corrupts
    // the checksum, bit 1 corrupts one tag byte if a tag is in use; a spoiled frame pins its status.
    task automatic send_frame(input int plen, input int fill, input int spoil);
        logic [7:0]  body[$];
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] len;
        logic [31:0] sum;
        logic [7:0]  b;
        logic [7:0]  flip;
        int          n;
        int          bad_at;
        result_t     st;
        n      = tag_span();
        len    = n + plen + 4;
        lo     = 16'd1;
        hi     = '0;
        bad_at = (spoil[1] && n != 0) ? $urandom_range(0, n - 1) : -1;
        flip   = 8'($urandom_range(1, 255));
        for (int i = 0; i < n; i++) begin
            b = 8'(tag_word >> (8 * (n - 1 - i)));
            if (i == bad_at) b = b ^ flip;
            body.push_back(b);
            adler_step(lo, hi, b);
        end
        for (int i = 0; i < plen; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            body.push_back(b);
            adler_step(lo, hi, b);
        end
        sum = {hi, lo};
        // the flip mask always holds at least one set bit
        if (spoil[0]) sum = sum ^ ((32'h1 << $urandom_range(0, 31)) | (32'($urandom) & 32'hF0F0));
        for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8], 1'b0, 1'b0, NO_RES);
        foreach (body[i]) put_byte(body[i], 1'b0, 1'b0, NO_RES);
        for (int i = 3; i >= 1; i--) put_byte(sum[8*i +: 8], 1'b0, 1'b0, NO_RES);
        if (spoil != 0) begin
            st = '{8'h00, 1'b1, spoil[0] ? ST_CHECKSUM : ST_TAG};
            put_byte(sum[7:0], 1'b1, 1'b1, st);
        end else begin
            put_byte(sum[7:0], 1'b0, 1'b0, NO_RES);
        end
    endtask

    // Random well-formed frames until the byte budget is spent. Mostly short
    // payloads, now and then an empty or a long one, clamped to max length.
    task automatic run_frames(input int budget);
        int     stop;
        int     pick;
        int     plen;
        longint room;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)      plen = 0;
            else if (pick == 1) plen = $urandom_range(40, 120);
            else                plen = $urandom_range(1, 20);
            room = longint'(max_len) - tag_span() - 4;
            if (plen > room) plen = int'(room);
            send_frame(plen, -1, 0);
        end
    endtask

    task automatic set_pace(input int sel);
        case (sel)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 81; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 27; stall_pct = 27; end
        endcase
    endtask

    // Close the run with one faulty frame; the block halts after it and must
    // drop the bytes that follow.
    task automatic end_with_fault();
        logic [31:0] len;
        int          kind;
        kind = $urandom_range(0, 5);
        len  = '0;
        case (kind)
            0: len = {1'b1, 31'($urandom)};                     // negative length
            1: begin                                             // above max length
                cfg_write(REG_MAX_LENGTH, ($urandom_range(0, 3) == 0) ? 32'd0
                                                                     : $urandom_range(4, 5000));
                len = $urandom_range(int'(max_len) + 1, 32'h7FFF_FFFF);
            end
            2: len = $urandom_range(0, tag_span() + 3);         // too short for tag + checksum
            3: send_frame($urandom_range(0, 12), -1, 1);        // bad checksum
            4: send_frame($urandom_range(0, 12), -1, (tag_span() != 0) ? 2 : 1);
            default: send_frame($urandom_range(0, 12), -1, 3);  // both bad: checksum wins
        endcase
        if (kind <= 2) begin
            for (int i = 3; i >= 1; i--) put_byte(len[8*i +: 8], 1'b1, 1'b0, NO_RES);
            put_byte(len[7:0], 1'b1, 1'b1, '{8'h00, 1'b1, ST_LENGTH});
        end
        // halted: these beats are dropped
        for (int i = 0; i < 8; i++) put_byte(8'($urandom), 1'b1, 1'b0, NO_RES);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_predictor();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames on reset config
        set_pace(0);
        for (int i = 0; i < 27; i++)
            put_byte(DIR_ROWS[i].din, 1'b1, DIR_ROWS[i].has, DIR_ROWS[i].want);
        drain();

        // widest max length (bit 31 of the write is dropped), all-ones tag of 4 bytes,
        // plus one long run of FF bytes that wraps both Adler sums
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);
        set_pace(0);
        send_frame(300, 8'hFF, 0);
        run_frames(190);
        drain();

        // tight max length with a two-byte tag, sender mostly idle
        set_config(32'd16, $urandom, 3'd2);
        set_pace(1);
        run_frames(150);
        drain();

        // oversized tag length caps at four bytes, receiver mostly stalled
        set_config($urandom_range(1000, 100000), $urandom, 3'd7);
        set_pace(2);
        run_frames(190);
        drain();

        // long hold-off: keep offering beats so the block fills and stalls its input
        set_config(32'd67108864, 32'h0000_0000, 3'd1);
        set_pace(0);
        -> hold_ev;
        run_frames(150);
        drain();

        // three-byte tag, max length leaves room for empty payloads only
        set_config(32'd7, $urandom, 3'd3);
        set_pace(3);
        run_frames(100);
        drain();

        // no tag, smallest usable max length
        set_config(32'd4, 32'h0000_0000, 3'd0);
        set_pace(3);
        run_frames(60);
        drain();

        // random settings, each pace in turn
        for (int p = 0; p < 4; p++) begin
            set_config(($urandom_range(0, 1) != 0) ? $urandom_range(8, 64) : ($urandom | 32'h100),
                       $urandom, 3'($urandom_range(0, 7)));
            set_pace(p);
            run_frames(50);
            drain();
        end

        end_with_fault();
        drain();
        repeat (8) @(negedge aclk);

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("tb_adler32_checked_frame_deframer: clean");
        end else begin
            $display("tb_adler32_checked_frame_deframer: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/acfd_pkg.sv
rtl/core/acfd_adler.sv
rtl/core/acfd_parser.sv
rtl/core/adler32_checked_frame_deframer.sv
dv/tb_adler32_checked_frame_deframer.sv
